[design/neighbor_byte_scrambler_top_defines.svh]
// ---------------------------------------------------------------------------
// neighbor byte scrambler assertion macros
// shared clocking and reset gating for the port checker
// ---------------------------------------------------------------------------
`ifndef NEIGHBOR_BYTE_SCRAMBLER_TOP_DEFINES_SVH
`define NEIGHBOR_BYTE_SCRAMBLER_TOP_DEFINES_SVH

// same-cycle implication, checked on the rising edge outside reset
`define NBS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nbs check failed");

// next-cycle implication, checked on the rising edge outside reset
`define NBS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nbs check failed");

`endif

[design/nbs_pkg.sv]
// ---------------------------------------------------------------------------
// nbs_pkg
// types, constants and helper functions of the neighbor byte scrambler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbs_pkg;

    // stream length from which results are flagged as too long
    localparam int unsigned MAX_LEN = 65536;
    localparam int LEN_W = 25;

    // running counter widths
    localparam int POS_W = 17;
    localparam int M13_W = 4;
    localparam int Q5_W  = 14;
    localparam int R5_W  = 3;

    // accumulator width, covers the full range of the pre-correction sum
    localparam int ACC_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [POS_W-1:0] POS_MAX  = '1;
    localparam logic [M13_W-1:0] M13_TOP  = M13_W'(12);
    localparam logic [R5_W-1:0]  R5_TOP   = R5_W'(4);
    localparam logic [ACC_W-1:0] BIAS     = ACC_W'(61);

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef enum logic [1:0] {
        KIND_MID,
        KIND_SOLO,
        KIND_PAIR
    } nbs_kind_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [M13_W-1:0] m13;
        logic [Q5_W-1:0]  q5;
        logic [R5_W-1:0]  r5;
    } nbs_cnt_t;

    // one queue entry: one or two results to produce
    typedef struct packed {
        nbs_kind_t        kind;
        logic [ACC_W-1:0] base_a;
        logic             prev_a;
        logic             too_a;
        logic [ACC_W-1:0] base_b;
        logic             too_b;
    } nbs_job_t;

    function automatic nbs_cnt_t advance(input nbs_cnt_t c);
        nbs_cnt_t n;
        n     = c;
        n.pos = (c.pos == POS_MAX) ? POS_MAX : c.pos + POS_W'(1);
        n.m13 = (c.m13 == '0 || c.m13 > M13_TOP) ? M13_TOP : c.m13 - M13_W'(1);
        if (c.r5 >= R5_TOP)
        begin
            n.r5 = '0;
            n.q5 = c.q5 + Q5_W'(1);
        end
        else
        begin
            n.r5 = c.r5 + R5_W'(1);
        end
        return n;
    endfunction

    function automatic logic [ACC_W-1:0] sext_byte(input logic [BYTE_W-1:0] b);
        return {{(ACC_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    // quot_five - rem_thirteen + byte + 61
    function automatic logic [ACC_W-1:0] base_term(input nbs_cnt_t c,
                                                   input logic [BYTE_W-1:0] cur);
        return {{(ACC_W-Q5_W){1'b0}}, c.q5} - {{(ACC_W-M13_W){1'b0}}, c.m13}
               + sext_byte(cur) + BIAS;
    endfunction

    // signed halving, rounding toward zero
    function automatic logic [BYTE_W-1:0] half_trunc(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] s;
        s = b + {{(BYTE_W-1){1'b0}}, b[BYTE_W-1]};
        return {s[BYTE_W-1], s[BYTE_W-1:1]};
    endfunction

    function automatic logic too_long_at(input logic [POS_W-1:0] pos);
        return {{(LEN_W-POS_W){1'b0}}, pos} >= LEN_W'(MAX_LEN);
    endfunction

endpackage

[design/nbs_front.sv]
// ---------------------------------------------------------------------------
// nbs_front
// lookahead holder and position counters, turns beats into queue jobs
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbs_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [nbs_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          in_last,
    output logic                          push,
    output nbs_pkg::nbs_job_t             job
);

    nbs_pkg::nbs_cnt_t               cnt_reg, cnt_next, cnt_adv;
    logic [nbs_pkg::BYTE_W-1:0]      held_byte_reg, held_byte_next;
    logic                            held_valid_reg, held_valid_next;

    always_comb
    begin
        cnt_adv         = nbs_pkg::advance(cnt_reg);
        cnt_next        = cnt_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        push            = 1'b0;

        job.kind   = nbs_pkg::KIND_MID;
        job.prev_a = (cnt_reg.pos != '0);
        job.too_a  = nbs_pkg::too_long_at(cnt_reg.pos);
        job.base_b = nbs_pkg::base_term(cnt_adv, in_byte);
        job.too_b  = nbs_pkg::too_long_at(cnt_adv.pos);
        if (held_valid_reg)
        begin
            job.base_a = nbs_pkg::base_term(cnt_reg, held_byte_reg)
                         - nbs_pkg::sext_byte(nbs_pkg::half_trunc(in_byte));
        end
        else
        begin
            job.base_a = nbs_pkg::base_term(cnt_reg, in_byte);
        end

        if (accept)
        begin
            if (!held_valid_reg)
            begin
                if (in_last)
                begin
                    // single-byte stream
                    push      = 1'b1;
                    job.kind  = nbs_pkg::KIND_SOLO;
                    cnt_next  = '0;
                end
                else
                begin
                    held_byte_next  = in_byte;
                    held_valid_next = 1'b1;
                end
            end
            else
            begin
                push = 1'b1;
                if (in_last)
                begin
                    job.kind        = nbs_pkg::KIND_PAIR;
                    cnt_next        = '0;
                    held_valid_next = 1'b0;
                    held_byte_next  = '0;
                end
                else
                begin
                    job.kind       = nbs_pkg::KIND_MID;
                    cnt_next       = cnt_adv;
                    held_byte_next = in_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_byte_reg <= held_byte_next;
    end

endmodule

[design/nbs_queue.sv]
// ---------------------------------------------------------------------------
// nbs_queue
// short job queue that decouples the front from the back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbs_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  nbs_pkg::nbs_job_t    job_in,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output nbs_pkg::nbs_job_t    job_out
);

    nbs_pkg::nbs_job_t               mem_reg [nbs_pkg::QDEPTH];
    logic [nbs_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [nbs_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [nbs_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                            do_push, do_pop;

    assign full    = (count_reg == nbs_pkg::QCNT_W'(nbs_pkg::QDEPTH));
    assign valid   = (count_reg != '0);
    assign job_out = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + nbs_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + nbs_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + nbs_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - nbs_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

[design/nbs_back.sv]
// ---------------------------------------------------------------------------
// nbs_back
// adds the previous output, applies the divide-by-255 correction, output stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbs_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  nbs_pkg::nbs_job_t             q_job,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [nbs_pkg::BYTE_W-1:0]    out_byte,
    output logic                          out_last,
    output logic                          too_long
);

    localparam int AW = nbs_pkg::ACC_W;
    localparam int BW = nbs_pkg::BYTE_W;

    logic            out_valid_reg, out_valid_next;
    logic [BW-1:0]   out_byte_reg, out_byte_next;
    logic            out_last_reg, out_last_next;
    logic            out_too_reg, out_too_next;
    logic            phase_reg, phase_next;
    logic [BW-1:0]   prior_reg, prior_next;

    logic            load;
    logic [AW-1:0]   sel_base, r_sum, r_mag, q_full;
    logic            sel_prev, sel_last, sel_too, sel_pair, r_neg;
    logic [BW-1:0]   q_low, result;

    assign load = q_valid && (!out_valid_reg || out_ready);

    // pick the job half for this beat
    always_comb
    begin
        sel_pair = 1'b0;
        sel_last = 1'b0;
        case (q_job.kind)
            nbs_pkg::KIND_MID:  sel_last = 1'b0;
            nbs_pkg::KIND_SOLO: sel_last = 1'b1;
            nbs_pkg::KIND_PAIR: sel_pair = 1'b1;
            default:            sel_last = 1'b0;
        endcase
        if (phase_reg)
        begin
            sel_base = q_job.base_b;
            sel_prev = 1'b1;
            sel_last = 1'b1;
            sel_too  = q_job.too_b;
        end
        else
        begin
            sel_base = q_job.base_a;
            sel_prev = q_job.prev_a;
            sel_too  = q_job.too_a;
        end
    end

    // r + trunc(r/255); |r| stays well below 65535 so the shift-add quotient is exact
    always_comb
    begin
        r_sum  = sel_base + (sel_prev ? nbs_pkg::sext_byte(prior_reg) : '0);
        r_neg  = r_sum[AW-1];
        r_mag  = r_neg ? (~r_sum + AW'(1)) : r_sum;
        q_full = (r_mag + AW'(1) + (r_mag >> 8)) >> 8;
        q_low  = q_full[BW-1:0];
        result = r_sum[BW-1:0] + (r_neg ? (~q_low + BW'(1)) : q_low);
    end

    always_comb
    begin
        q_pop          = 1'b0;
        phase_next     = phase_reg;
        prior_next     = prior_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_too_next   = out_too_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = result;
            out_last_next  = sel_last && !(sel_pair && !phase_reg);
            out_too_next   = sel_too;
            prior_next     = result;
            q_pop          = phase_reg || !sel_pair;
            phase_next     = !phase_reg && sel_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            prior_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            prior_reg     <= prior_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_too_reg  <= out_too_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign too_long  = out_too_reg;

endmodule

[design/neighbor_byte_scrambler_top.sv]
// ---------------------------------------------------------------------------
// neighbor_byte_scrambler_top
// scrambles a stream of signed bytes against its neighbours and position
// ---------------------------------------------------------------------------
//
//  channel  | dir | tdata              | tuser       | tlast
//  ---------+-----+--------------------+-------------+-------------------
//  s_axis   | in  | [7:0] in_byte      | -           | in_last
//  m_axis   | out | [7:0] out_byte     | [0] too_long| out_last
//
//  one input beat per cycle is taken while the job queue has room; the
//  rate is set by the back end's loop through the previous output byte
//  (add, divide-by-255 correction, register)
//  a beat yields the result of the byte held before it; a final beat after
//  a held byte yields two results, sent in turn from one queue entry
//  each job reaches m_axis through the queue and the output register
//  asynchronous active-low reset clears counters, queue and output valid
//  a stalled m_axis fills the four-entry queue, then s_axis_tready drops
//
`timescale 1ns / 1ps

module neighbor_byte_scrambler_top
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic        s_axis_tlast,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
    output logic [0:0]  m_axis_tuser,    // [0] too_long
    output logic        m_axis_tlast
);

    logic              q_full;
    logic              q_valid;
    logic              q_pop;
    logic              push;
    logic              accept;
    logic              too_long;
    nbs_pkg::nbs_job_t job_in;
    nbs_pkg::nbs_job_t job_out;

    // take a beat whenever the queue can absorb the job it may produce
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // front: lookahead byte, position counters, base terms of each result
    nbs_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (s_axis_tdata),
        .in_last (s_axis_tlast),
        .push    (push),
        .job     (job_in)
    );

    // decoupling queue
    nbs_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .job_out (job_out)
    );

    // back: previous-output feedback and correction, registered output beat
    nbs_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (job_out),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .too_long  (too_long)
    );

    assign m_axis_tuser = too_long;

endmodule

[design/nbs_checker.sv]
// ---------------------------------------------------------------------------
// nbs_checker
// port-level checks on the scrambler, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "neighbor_byte_scrambler_top_defines.svh"

module nbs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a held output beat stays offered
    `NBS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a held output beat keeps its data
    `NBS_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // input back-pressure only ever comes from a pending output beat
    `NBS_ASSERT_IMP(a_bp_cause, !s_axis_tready, m_axis_tvalid)

    // a fresh output beat goes back to an accepted input beat, via the queue and the output register
    `NBS_ASSERT_IMP(a_out_origin, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind neighbor_byte_scrambler_top nbs_checker u_nbs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
